// File: src/scba_pkg.sv
// Shared types and constants of the size-class block allocator.
// Holds the word field widths, opcode and status codes, and the command and
// status structs between the controller and the datapath. No dependencies.
`default_nettype none

package scba_pkg;

   localparam int KIND_W   = 2;
   localparam int HANDLE_W = 10;
   localparam int COUNT_W  = 14;
   localparam int ADDR_W   = 32;
   localparam int STATUS_W = 3;

   // The rounded count never reaches twice the count range.
   localparam int SUM_W = COUNT_W + 1;

   localparam int DEF_MAX_BLOCK  = 8192;
   localparam int DEF_BLOCK_INCR = 256;
   localparam int DEF_UNIT_BYTES = 4;
   localparam int DEF_NUM_DESC   = 1024;

   typedef logic [KIND_W-1:0] kind_type;
   localparam kind_type KIND_ALLOC   = 2'd0;
   localparam kind_type KIND_RELEASE = 2'd1;
   localparam kind_type KIND_WRITE   = 2'd2;
   localparam kind_type KIND_READ    = 2'd3;

   typedef logic [STATUS_W-1:0] status_type;
   localparam status_type ST_OK        = 3'd0;
   localparam status_type ST_OVER_MAX  = 3'd1;
   localparam status_type ST_NO_DESC   = 3'd2;
   localparam status_type ST_READ_OVER = 3'd3;
   localparam status_type ST_ADDR_OVF  = 3'd4;

   typedef logic [2:0] res_op_type;
   localparam res_op_type RES_HOLD  = 3'd0;
   localparam res_op_type RES_ERR   = 3'd1;
   localparam res_op_type RES_POP   = 3'd2;
   localparam res_op_type RES_FRESH = 3'd3;
   localparam res_op_type RES_KEEP  = 3'd4;
   localparam res_op_type RES_READ  = 3'd5;

   typedef struct packed {
      logic       latch;
      logic       clear;
      logic       rd_desc;
      logic       cu_from_mem;
      logic       cap_new;
      logic       cap_old;
      logic       rd_head_new;
      logic       rd_head_old;
      logic       plan;
      logic       link;
      logic       commit_fresh;
      logic       rd_pop;
      logic       pop;
      logic       same_write;
      logic       load_rsp;
      res_op_type res_op;
      status_type err_code;
   } scba_cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     bad_handle;
      logic     over_max;
      logic     cls_same;
      logic     head_valid;
      logic     fresh_full;
      logic     addr_ovf;
      logic     pop_sel;
      logic     clr_done;
   } scba_stat_type;

endpackage

`default_nettype wire

// File: src/scba_class.sv
// Size class unit: ceil(units / BLOCK_INCR), clamped to the last class.
// Free-running pipeline with two register stages, a reciprocal multiply and one
// correction step; the class follows the units through both stages. Depends on scba_pkg.
`default_nettype none

module scba_class
   import scba_pkg::*;
#(
   parameter int  MAX_BLOCK  = DEF_MAX_BLOCK,
   parameter int  BLOCK_INCR = DEF_BLOCK_INCR,
   localparam int NCLASS     = (MAX_BLOCK + BLOCK_INCR - 1) / BLOCK_INCR + 1,
   localparam int CLS_W      = $clog2(NCLASS)
)(
   input  wire              clock,
   input  wire  [COUNT_W-1:0] units,
   output logic [CLS_W-1:0]   size_class
);

   localparam int RECIP_W = SUM_W + 1;
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'((2 ** SUM_W) / BLOCK_INCR);
   localparam logic [SUM_W-1:0]   ROUND_ADD = SUM_W'(BLOCK_INCR - 1);
   localparam logic [SUM_W-1:0]   INCR_S    = SUM_W'(BLOCK_INCR);

   logic [SUM_W-1:0]   sum_in, sum_ff, sum2_in, sum2_ff;
   logic [PROD_W-1:0]  prod_in, prod_ff;
   logic [RECIP_W-1:0] quot_in, quot_ff;
   logic [SUM_W-1:0]   back;
   logic [SUM_W-1:0]   rem;
   logic [RECIP_W-1:0] fixed;

   always_comb begin
      sum_in  = SUM_W'(units) + ROUND_ADD;
      prod_in = PROD_W'(sum_in) * PROD_W'(RECIP);
      sum2_in = sum_ff;
      // The estimate is the true quotient or one below it.
      quot_in = prod_ff[PROD_W-1:SUM_W];
   end

   always_ff @(posedge clock) begin
      sum_ff  <= sum_in;
      prod_ff <= prod_in;
      sum2_ff <= sum2_in;
      quot_ff <= quot_in;
   end

   always_comb begin
      back  = SUM_W'(PROD_W'(quot_ff) * PROD_W'(BLOCK_INCR));
      rem   = sum2_ff - back;
      fixed = quot_ff + RECIP_W'(rem >= INCR_S);
      if (32'(fixed) > NCLASS - 1) begin
         size_class = CLS_W'(NCLASS - 1);
      end else begin
         size_class = CLS_W'(fixed);
      end
   end

endmodule

`default_nettype wire

// File: src/scba_dp.sv
// Datapath of the allocator: request latch, class registers, descriptor and
// class-head memories, bump pointer and result registers. Driven by commands
// from scba_ctrl. Depends on scba_pkg and scba_class.
`default_nettype none

module scba_dp
   import scba_pkg::*;
#(
   parameter int MAX_BLOCK  = DEF_MAX_BLOCK,
   parameter int BLOCK_INCR = DEF_BLOCK_INCR,
   parameter int UNIT_BYTES = DEF_UNIT_BYTES,
   parameter int NUM_DESC   = DEF_NUM_DESC
)(
   input  wire                  clock,
   input  wire                  reset,
   input  wire  [KIND_W-1:0]    req_kind,
   input  wire  [HANDLE_W-1:0]  req_handle,
   input  wire  [COUNT_W-1:0]   req_count,
   input  wire  scba_cmd_type   cmd,
   output scba_stat_type        stat,
   output logic [HANDLE_W-1:0]  rsp_result_handle,
   output logic [ADDR_W-1:0]    rsp_byte_addr,
   output logic [STATUS_W-1:0]  rsp_status
);

   localparam int NCLASS      = (MAX_BLOCK + BLOCK_INCR - 1) / BLOCK_INCR + 1;
   localparam int CLS_W       = $clog2(NCLASS);
   localparam int DESC_W      = $clog2(NUM_DESC);
   localparam int FRESH_W     = DESC_W + 1;
   localparam int LINK_W      = DESC_W + 1;
   localparam int BLOCK_BYTES = BLOCK_INCR * UNIT_BYTES;

   // List entries hold a valid bit above the descriptor number.
   logic [LINK_W-1:0]  class_mem [NCLASS];
   logic [LINK_W-1:0]  link_mem  [NUM_DESC];
   logic [ADDR_W-1:0]  addr_mem  [NUM_DESC];
   logic [COUNT_W-1:0] count_mem [NUM_DESC];

   logic [LINK_W-1:0]  cls_rd_ff, link_rd_ff;
   logic [ADDR_W-1:0]  addr_rd_ff;
   logic [COUNT_W-1:0] cnt_rd_ff;

   kind_type           kind_in, kind_ff;
   logic [HANDLE_W-1:0] handle_in, handle_ff;
   logic [COUNT_W-1:0] count_in, count_ff;
   logic [CLS_W-1:0]   cls_new_in, cls_new_ff, cls_old_in, cls_old_ff;
   logic [ADDR_W-1:0]  bytes_in, bytes_ff;
   logic [DESC_W-1:0]  h_in, h_ff;
   logic               pop_in, pop_ff;
   logic [FRESH_W-1:0] fresh_in, fresh_ff;
   logic [ADDR_W-1:0]  next_free_in, next_free_ff;
   logic [CLS_W-1:0]   clr_idx_in, clr_idx_ff;
   logic [HANDLE_W-1:0] res_handle_in, res_handle_ff;
   logic [ADDR_W-1:0]  res_addr_in, res_addr_ff;
   status_type         res_status_in, res_status_ff;
   logic [HANDLE_W-1:0] rsp_handle_in, rsp_handle_ff;
   logic [ADDR_W-1:0]  rsp_addr_in, rsp_addr_ff;
   status_type         rsp_status_in, rsp_status_ff;

   logic [COUNT_W-1:0] cu_units;
   logic [CLS_W-1:0]   size_class;
   logic [DESC_W-1:0]  hidx;
   logic [ADDR_W:0]    addr_sum;
   logic               cls_we;
   logic [CLS_W-1:0]   cls_wa;
   logic [LINK_W-1:0]  cls_wd;
   logic [CLS_W-1:0]   cls_ra;
   logic               cnt_we;
   logic [DESC_W-1:0]  cnt_wa;
   logic [DESC_W-1:0]  addr_ra;

   assign cu_units = cmd.cu_from_mem ? cnt_rd_ff : count_ff;

   scba_class #(
      .MAX_BLOCK  (MAX_BLOCK),
      .BLOCK_INCR (BLOCK_INCR)
   ) u_class (
      .clock      (clock),
      .units      (cu_units),
      .size_class (size_class)
   );

   assign hidx     = DESC_W'(handle_ff);
   assign addr_sum = {1'b0, next_free_ff} + {1'b0, bytes_ff};

   always_comb begin
      stat.kind       = kind_ff;
      stat.bad_handle = 32'(handle_ff) >= NUM_DESC;
      stat.over_max   = 32'(count_ff) > MAX_BLOCK;
      stat.cls_same   = cls_new_ff == cls_old_ff;
      stat.head_valid = cls_rd_ff[LINK_W-1];
      stat.fresh_full = 32'(fresh_ff) >= NUM_DESC;
      stat.addr_ovf   = addr_sum[ADDR_W];
      stat.pop_sel    = pop_ff;
      stat.clr_done   = 32'(clr_idx_ff) == NCLASS - 1;
   end

   always_comb begin
      kind_in      = cmd.latch ? kind_type'(req_kind) : kind_ff;
      handle_in    = cmd.latch ? req_handle : handle_ff;
      count_in     = cmd.latch ? req_count : count_ff;
      cls_new_in   = cmd.cap_new ? size_class : cls_new_ff;
      cls_old_in   = cmd.cap_old ? size_class : cls_old_ff;
      bytes_in     = ADDR_W'(cls_new_ff) * ADDR_W'(BLOCK_BYTES);
      h_in         = h_ff;
      pop_in       = pop_ff;
      if (cmd.plan) begin
         pop_in = cls_rd_ff[LINK_W-1];
         h_in   = cls_rd_ff[LINK_W-1] ? cls_rd_ff[DESC_W-1:0] : fresh_ff[DESC_W-1:0];
      end
      fresh_in     = cmd.commit_fresh ? fresh_ff + FRESH_W'(1) : fresh_ff;
      next_free_in = cmd.commit_fresh ? addr_sum[ADDR_W-1:0] : next_free_ff;
      clr_idx_in   = cmd.clear ? clr_idx_ff + CLS_W'(1) : clr_idx_ff;
   end

   always_comb begin
      res_handle_in = res_handle_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      unique case (cmd.res_op)
         RES_HOLD: begin
         end
         RES_ERR: begin
            res_handle_in = (kind_ff == KIND_ALLOC) ? '0 : handle_ff;
            res_addr_in   = '0;
            res_status_in = cmd.err_code;
         end
         RES_POP: begin
            res_handle_in = HANDLE_W'(h_ff);
            res_addr_in   = addr_rd_ff;
            res_status_in = ST_OK;
         end
         RES_FRESH: begin
            res_handle_in = HANDLE_W'(h_ff);
            res_addr_in   = next_free_ff;
            res_status_in = ST_OK;
         end
         RES_KEEP: begin
            res_handle_in = handle_ff;
            res_addr_in   = addr_rd_ff;
            res_status_in = ST_OK;
         end
         RES_READ: begin
            res_handle_in = handle_ff;
            res_addr_in   = addr_rd_ff;
            res_status_in = (count_ff > cnt_rd_ff) ? ST_READ_OVER : ST_OK;
         end
         default: begin
         end
      endcase
      rsp_handle_in = cmd.load_rsp ? res_handle_ff : rsp_handle_ff;
      rsp_addr_in   = cmd.load_rsp ? res_addr_ff : rsp_addr_ff;
      rsp_status_in = cmd.load_rsp ? res_status_ff : rsp_status_ff;
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      handle_ff     <= handle_in;
      count_ff      <= count_in;
      cls_new_ff    <= cls_new_in;
      cls_old_ff    <= cls_old_in;
      bytes_ff      <= bytes_in;
      h_ff          <= h_in;
      pop_ff        <= pop_in;
      res_handle_ff <= res_handle_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_ff     <= '0;
         next_free_ff <= '0;
         clr_idx_ff   <= '0;
      end else begin
         fresh_ff     <= fresh_in;
         next_free_ff <= next_free_in;
         clr_idx_ff   <= clr_idx_in;
      end
   end

   // Class-head memory: cleared after reset, then written on push and pop.
   always_comb begin
      cls_we = cmd.clear || cmd.link || cmd.pop;
      cls_wa = cls_new_ff;
      cls_wd = link_rd_ff;
      if (cmd.clear) begin
         cls_wa = clr_idx_ff;
         cls_wd = '0;
      end else if (cmd.link) begin
         cls_wa = cls_old_ff;
         cls_wd = {1'b1, hidx};
      end
      cls_ra  = cmd.rd_head_old ? cls_old_ff : cls_new_ff;
      cnt_we  = cmd.same_write || cmd.commit_fresh || cmd.pop;
      cnt_wa  = cmd.same_write ? hidx : h_ff;
      addr_ra = cmd.rd_pop ? h_ff : hidx;
   end

   always_ff @(posedge clock) begin
      if (cls_we) begin
         class_mem[cls_wa] <= cls_wd;
      end
      if (cmd.rd_head_new || cmd.rd_head_old) begin
         cls_rd_ff <= class_mem[cls_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.link) begin
         link_mem[hidx] <= cls_rd_ff;
      end
      if (cmd.rd_pop) begin
         link_rd_ff <= link_mem[h_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit_fresh) begin
         addr_mem[h_ff] <= next_free_ff;
      end
      if (cmd.rd_desc || cmd.rd_pop) begin
         addr_rd_ff <= addr_mem[addr_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         count_mem[cnt_wa] <= count_ff;
      end
      if (cmd.rd_desc) begin
         cnt_rd_ff <= count_mem[hidx];
      end
   end

   assign rsp_result_handle = rsp_handle_ff;
   assign rsp_byte_addr     = rsp_addr_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

`default_nettype wire

// File: src/scba_ctrl.sv
// Controller of the allocator: sequences the clearing pass, the class unit,
// memory reads and writes, and the result handshake. Depends on scba_pkg.
`default_nettype none

module scba_ctrl
   import scba_pkg::*;
(
   input  wire            clock,
   input  wire            reset,
   input  wire            req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  wire            rsp_stall,
   input  wire  scba_stat_type stat,
   output scba_cmd_type   cmd
);

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_CHECK    = 4'd2;
   localparam logic [3:0] S_CNT      = 4'd3;
   localparam logic [3:0] S_CLS_A    = 4'd4;
   localparam logic [3:0] S_CLS_B    = 4'd5;
   localparam logic [3:0] S_SAME     = 4'd6;
   localparam logic [3:0] S_HEAD_NEW = 4'd7;
   localparam logic [3:0] S_PLAN     = 4'd8;
   localparam logic [3:0] S_HEAD_OLD = 4'd9;
   localparam logic [3:0] S_LINK     = 4'd10;
   localparam logic [3:0] S_COMMIT   = 4'd11;
   localparam logic [3:0] S_POP      = 4'd12;
   localparam logic [3:0] S_READ     = 4'd13;
   localparam logic [3:0] S_FIN      = 4'd14;

   logic [3:0] state_in, state_ff;
   logic       rsp_valid_in, rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clr_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_CHECK;
            end
         end
         S_CHECK: begin
            priority if (stat.kind == KIND_ALLOC && stat.over_max) begin
               cmd.res_op   = RES_ERR;
               cmd.err_code = ST_OVER_MAX;
               state_in     = S_FIN;
            end else if (stat.kind == KIND_ALLOC) begin
               state_in = S_CLS_A;
            end else if (stat.bad_handle) begin
               cmd.res_op   = RES_ERR;
               cmd.err_code = ST_NO_DESC;
               state_in     = S_FIN;
            end else if (stat.kind == KIND_WRITE && stat.over_max) begin
               cmd.res_op   = RES_ERR;
               cmd.err_code = ST_OVER_MAX;
               state_in     = S_FIN;
            end else if (stat.kind == KIND_READ) begin
               cmd.rd_desc = 1'b1;
               state_in    = S_READ;
            end else begin
               cmd.rd_desc = 1'b1;
               state_in    = S_CNT;
            end
         end
         S_CNT: begin
            // Stored count of the handle enters the class unit in the cycle
            // after the request count.
            cmd.cu_from_mem = 1'b1;
            state_in        = S_CLS_A;
         end
         S_CLS_A: begin
            cmd.cap_new = 1'b1;
            state_in    = S_CLS_B;
         end
         S_CLS_B: begin
            if (stat.kind == KIND_ALLOC) begin
               cmd.cap_new = 1'b1;
               state_in    = S_HEAD_NEW;
            end else if (stat.kind == KIND_RELEASE) begin
               cmd.cap_old = 1'b1;
               state_in    = S_HEAD_OLD;
            end else begin
               cmd.cap_old = 1'b1;
               state_in    = S_SAME;
            end
         end
         S_SAME: begin
            if (stat.cls_same) begin
               cmd.same_write = 1'b1;
               cmd.res_op     = RES_KEEP;
               state_in       = S_FIN;
            end else begin
               state_in = S_HEAD_NEW;
            end
         end
         S_HEAD_NEW: begin
            cmd.rd_head_new = 1'b1;
            state_in        = S_PLAN;
         end
         S_PLAN: begin
            priority if (stat.head_valid) begin
               cmd.plan = 1'b1;
               state_in = (stat.kind == KIND_ALLOC) ? S_COMMIT : S_HEAD_OLD;
            end else if (stat.fresh_full) begin
               cmd.res_op   = RES_ERR;
               cmd.err_code = ST_NO_DESC;
               state_in     = S_FIN;
            end else if (stat.addr_ovf) begin
               cmd.res_op   = RES_ERR;
               cmd.err_code = ST_ADDR_OVF;
               state_in     = S_FIN;
            end else begin
               cmd.plan = 1'b1;
               state_in = (stat.kind == KIND_ALLOC) ? S_COMMIT : S_HEAD_OLD;
            end
         end
         S_HEAD_OLD: begin
            cmd.rd_head_old = 1'b1;
            state_in        = S_LINK;
         end
         S_LINK: begin
            cmd.link = 1'b1;
            if (stat.kind == KIND_RELEASE) begin
               cmd.res_op = RES_KEEP;
               state_in   = S_FIN;
            end else begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (stat.pop_sel) begin
               cmd.rd_pop = 1'b1;
               state_in   = S_POP;
            end else begin
               cmd.commit_fresh = 1'b1;
               cmd.res_op       = RES_FRESH;
               state_in         = S_FIN;
            end
         end
         S_POP: begin
            cmd.pop    = 1'b1;
            cmd.res_op = RES_POP;
            state_in   = S_FIN;
         end
         S_READ: begin
            cmd.res_op = RES_READ;
            state_in   = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: src/size_class_block_allocator_top.sv
// Size-class block allocator, top level. One word in, one word out.
// req_stall falls with rsp_valid: a new word is taken only once the result of the
// last one is loaded for output, and a stalled result holds the block in S_FIN.
// After reset the class-head memory is cleared, one class per cycle, for all NCLASS
// classes (33 at default settings), and req_stall stays high meanwhile.
`default_nettype none

module size_class_block_allocator_top
   import scba_pkg::*;
#(
   parameter int MAX_BLOCK  = DEF_MAX_BLOCK,
   parameter int BLOCK_INCR = DEF_BLOCK_INCR,
   parameter int UNIT_BYTES = DEF_UNIT_BYTES,
   parameter int NUM_DESC   = DEF_NUM_DESC
)(
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  wire  [KIND_W-1:0]    req_kind,
   input  wire  [HANDLE_W-1:0]  req_handle,
   input  wire  [COUNT_W-1:0]   req_count,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output logic [HANDLE_W-1:0]  rsp_result_handle,
   output logic [ADDR_W-1:0]    rsp_byte_addr,
   output logic [STATUS_W-1:0]  rsp_status
);

   scba_cmd_type  cmd;
   scba_stat_type stat;

   scba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   scba_dp #(
      .MAX_BLOCK  (MAX_BLOCK),
      .BLOCK_INCR (BLOCK_INCR),
      .UNIT_BYTES (UNIT_BYTES),
      .NUM_DESC   (NUM_DESC)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_kind          (req_kind),
      .req_handle        (req_handle),
      .req_count         (req_count),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_result_handle (rsp_result_handle),
      .rsp_byte_addr     (rsp_byte_addr),
      .rsp_status        (rsp_status)
   );

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for size_class_block_allocator_top.
// Drives allocate, release, write-resize and read-check words, predicts every
// result word with a model kept here, and depends only on scba_pkg and the top.
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import scba_pkg::*;

   localparam int LIM_UNITS   = DEF_MAX_BLOCK;
   localparam int STEP_UNITS  = DEF_BLOCK_INCR;
   localparam int UNIT_SIZE   = DEF_UNIT_BYTES;
   localparam int DESC_TOTAL  = DEF_NUM_DESC;
   localparam int CLASS_TOTAL = (LIM_UNITS + STEP_UNITS - 1) / STEP_UNITS + 1;
   localparam int SCRIPT_LEN  = 25;

   typedef struct packed {
      logic [HANDLE_W-1:0] hdl;
      logic [ADDR_W-1:0]   addr;
      status_type          status;
   } alloc_result_type;

   typedef struct packed {
      kind_type            kind;
      logic [HANDLE_W-1:0] handle;
      logic [COUNT_W-1:0]  count;
      logic                typed;
      alloc_result_type    want;
   } script_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [KIND_W-1:0]   req_kind = '0;
   logic [HANDLE_W-1:0] req_handle = '0;
   logic [COUNT_W-1:0]  req_count = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b1;
   logic [HANDLE_W-1:0] rsp_result_handle;
   logic [ADDR_W-1:0]   rsp_byte_addr;
   logic [STATUS_W-1:0] rsp_status;

   // Allocator state as the predictor sees it.
   bit                  head_valid [CLASS_TOTAL];
   logic [HANDLE_W-1:0] head_desc  [CLASS_TOTAL];
   bit                  link_valid [DESC_TOTAL];
   logic [HANDLE_W-1:0] link_desc  [DESC_TOTAL];
   logic [ADDR_W-1:0]   blk_addr   [DESC_TOTAL];
   logic [COUNT_W-1:0]  blk_units  [DESC_TOTAL];
   logic [HANDLE_W:0]   fresh_cnt = '0;
   logic [ADDR_W-1:0]   addr_top = '0;

   alloc_result_type    expected_words[$];
   logic [HANDLE_W-1:0] live_q[$];
   int                  mismatches = 0;
   int                  rsp_seen = 0;
   bit                  no_idle = 1'b0;

   // Rows with typed = 1 carry a result that follows directly from reset state or
   // from an error code; the rest are checked against the predictor.
   script_row_type script [SCRIPT_LEN] = '{
      '{KIND_ALLOC,   10'h3FF, 14'd0,     1'b1, '{10'd0, 32'd0,    ST_OK}},
      '{KIND_ALLOC,   10'd0,   14'd8193,  1'b1, '{10'd0, 32'd0,    ST_OVER_MAX}},
      '{KIND_ALLOC,   10'h3FF, 14'h3FFF,  1'b1, '{10'd0, 32'd0,    ST_OVER_MAX}},
      '{KIND_ALLOC,   10'd0,   14'd1,     1'b1, '{10'd1, 32'd0,    ST_OK}},
      '{KIND_ALLOC,   10'd0,   14'd8192,  1'b1, '{10'd2, 32'd1024, ST_OK}},
      '{KIND_ALLOC,   10'd5,   14'd256,   1'b0, '0},
      '{KIND_ALLOC,   10'd0,   14'd257,   1'b0, '0},
      '{KIND_WRITE,   10'd2,   14'h3FFF,  1'b1, '{10'd2, 32'd0,    ST_OVER_MAX}},
      '{KIND_WRITE,   10'd2,   14'd8193,  1'b1, '{10'd2, 32'd0,    ST_OVER_MAX}},
      '{KIND_READ,    10'd2,   14'd8192,  1'b1, '{10'd2, 32'd1024, ST_OK}},
      '{KIND_READ,    10'd2,   14'd8193,  1'b1, '{10'd2, 32'd1024, ST_READ_OVER}},
      '{KIND_READ,    10'd1,   14'd0,     1'b0, '0},
      '{KIND_WRITE,   10'd1,   14'd200,   1'b0, '0},
      '{KIND_WRITE,   10'd1,   14'd256,   1'b0, '0},
      '{KIND_WRITE,   10'd3,   14'd512,   1'b0, '0},
      '{KIND_RELEASE, 10'd1,   14'd0,     1'b0, '0},
      '{KIND_RELEASE, 10'd4,   14'd0,     1'b0, '0},
      '{KIND_ALLOC,   10'd0,   14'd100,   1'b0, '0},
      '{KIND_ALLOC,   10'd0,   14'd1,     1'b0, '0},
      '{KIND_ALLOC,   10'd0,   14'd512,   1'b0, '0},
      '{KIND_WRITE,   10'd0,   14'd8192,  1'b0, '0},
      '{KIND_RELEASE, 10'd0,   14'd0,     1'b0, '0},
      '{KIND_ALLOC,   10'd0,   14'd0,     1'b0, '0},
      '{KIND_ALLOC,   10'd0,   14'd0,     1'b0, '0},
      '{KIND_READ,    10'd6,   14'd8192,  1'b0, '0}
   };

   size_class_block_allocator_top #(
      .MAX_BLOCK  (LIM_UNITS),
      .BLOCK_INCR (STEP_UNITS),
      .UNIT_BYTES (UNIT_SIZE),
      .NUM_DESC   (DESC_TOTAL)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_handle        (req_handle),
      .req_count         (req_count),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_handle (rsp_result_handle),
      .rsp_byte_addr     (rsp_byte_addr),
      .rsp_status        (rsp_status)
   );

   always #2 clock = ~clock;

   function automatic int size_class(input logic [COUNT_W-1:0] n);
      int c;
      c = (int'(n) + STEP_UNITS - 1) / STEP_UNITS;
      return (c < CLASS_TOTAL) ? c : CLASS_TOTAL - 1;
   endfunction

   function automatic longint unsigned block_bytes(input logic [COUNT_W-1:0] n);
      longint unsigned blocks;
      blocks = (longint'(n) + STEP_UNITS - 1) / STEP_UNITS;
      return blocks * STEP_UNITS * UNIT_SIZE;
   endfunction

   // Chooses the descriptor for an allocation without touching any state.
   function automatic status_type plan_block(input logic [COUNT_W-1:0] n,
                                             output logic [HANDLE_W-1:0] h);
      int c;
      c = size_class(n);
      h = '0;
      if (head_valid[c]) begin
         h = head_desc[c];
         return ST_OK;
      end
      if (fresh_cnt >= DESC_TOTAL)
         return ST_NO_DESC;
      if (longint'(addr_top) + block_bytes(n) > 64'hFFFF_FFFF)
         return ST_ADDR_OVF;
      h = fresh_cnt[HANDLE_W-1:0];
      return ST_OK;
   endfunction

   function automatic void take_block(input logic [COUNT_W-1:0] n,
                                      input logic [HANDLE_W-1:0] h);
      int c;
      c = size_class(n);
      if (head_valid[c]) begin
         head_valid[c] = link_valid[h];
         head_desc[c] = link_desc[h];
      end else begin
         blk_addr[h] = addr_top;
         addr_top = ADDR_W'(longint'(addr_top) + block_bytes(n));
         fresh_cnt = fresh_cnt + 1'b1;
      end
      blk_units[h] = n;
   endfunction

   function automatic void free_block(input logic [HANDLE_W-1:0] h);
      int c;
      c = size_class(blk_units[h]);
      link_valid[h] = head_valid[c];
      link_desc[h] = head_desc[c];
      head_valid[c] = 1'b1;
      head_desc[c] = h;
   endfunction

   function automatic alloc_result_type step_allocator(input kind_type k,
                                                       input logic [HANDLE_W-1:0] h,
                                                       input logic [COUNT_W-1:0] n);
      alloc_result_type    r;
      logic [HANDLE_W-1:0] pick;
      r.hdl = (k == KIND_ALLOC) ? '0 : h;
      r.addr = '0;
      r.status = ST_OK;
      pick = '0;
      if (k == KIND_ALLOC) begin
         if (n > LIM_UNITS) begin
            r.status = ST_OVER_MAX;
         end else begin
            r.status = plan_block(n, pick);
            if (r.status == ST_OK) begin
               take_block(n, pick);
               r.hdl = pick;
               r.addr = blk_addr[pick];
            end
         end
      end else if (h >= DESC_TOTAL) begin
         r.status = ST_NO_DESC;
      end else if (k == KIND_RELEASE) begin
         free_block(h);
         r.addr = blk_addr[h];
      end else if (k == KIND_WRITE) begin
         if (n > LIM_UNITS) begin
            r.status = ST_OVER_MAX;
         end else if (size_class(blk_units[h]) == size_class(n)) begin
            blk_units[h] = n;
            r.addr = blk_addr[h];
         end else begin
            // The new block is planned before the old one goes back, so a
            // failed write leaves every list as it was.
            r.status = plan_block(n, pick);
            if (r.status == ST_OK) begin
               free_block(h);
               take_block(n, pick);
               r.hdl = pick;
               r.addr = blk_addr[pick];
            end
         end
      end else begin
         r.addr = blk_addr[h];
         if (n > blk_units[h])
            r.status = ST_READ_OVER;
      end
      return r;
   endfunction

   function automatic logic [COUNT_W-1:0] pick_units();
      int unsigned r;
      int unsigned c;
      r = $urandom_range(0, 19);
      unique case (r)
         0: return COUNT_W'($urandom_range(LIM_UNITS + 1, (1 << COUNT_W) - 1));
         1: return '0;
         2: return COUNT_W'(LIM_UNITS);
         3: begin
            // Straddle a class boundary.
            c = $urandom_range(1, CLASS_TOTAL - 1) * STEP_UNITS;
            return COUNT_W'(c + $urandom_range(0, 2) - 1);
         end
         default: return COUNT_W'($urandom_range(0, LIM_UNITS));
      endcase
   endfunction

   // Handles other than allocate come from issued descriptors only, mostly
   // from live ones; a few reuse released descriptors on purpose.
   task automatic pick_word(output kind_type k, output logic [HANDLE_W-1:0] h,
                            output logic [COUNT_W-1:0] n);
      int unsigned r;
      int unsigned c;
      int unsigned lo;
      int unsigned hi;
      r = $urandom_range(0, 99);
      k = (fresh_cnt == 0 || r < 35) ? KIND_ALLOC :
          (r < 60) ? KIND_RELEASE : (r < 85) ? KIND_WRITE : KIND_READ;
      if (k == KIND_ALLOC)
         h = HANDLE_W'($urandom);
      else if (live_q.size() != 0 && $urandom_range(0, 19) != 0)
         h = live_q[$urandom_range(0, live_q.size() - 1)];
      else
         h = HANDLE_W'($urandom_range(0, fresh_cnt - 1));
      n = pick_units();
      if (k == KIND_READ && $urandom_range(0, 1) == 1)
         n = blk_units[h] + COUNT_W'($urandom_range(0, 2)) - COUNT_W'(1);
      if (k == KIND_WRITE && $urandom_range(0, 1) == 1) begin
         c = size_class(blk_units[h]);
         lo = (c == 0) ? 0 : (c - 1) * STEP_UNITS + 1;
         hi = (c * STEP_UNITS > LIM_UNITS) ? LIM_UNITS : c * STEP_UNITS;
         n = COUNT_W'($urandom_range(lo, hi));
      end
   endtask

   // Called at a rising edge; returns at the edge where the word is accepted.
   // Valid stays high into the next word when no gap is drawn.
   task automatic send_word(input kind_type k, input logic [HANDLE_W-1:0] h,
                            input logic [COUNT_W-1:0] n, input logic typed,
                            input alloc_result_type want);
      int               gap;
      alloc_result_type pred;
      int               idx[$];
      gap = no_idle ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= k;
      req_handle <= h;
      req_count <= n;
      do @(posedge clock); while (req_stall !== 1'b0);
      pred = step_allocator(k, h, n);
      expected_words.push_back(typed ? want : pred);
      if (pred.status == ST_OK) begin
         if (k == KIND_RELEASE || k == KIND_WRITE) begin
            idx = live_q.find_first_index(item) with (item == h);
            if (idx.size() != 0)
               live_q.delete(idx[0]);
         end
         if (k == KIND_ALLOC || k == KIND_WRITE)
            live_q.push_back(pred.hdl);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   task automatic run_random(input int words);
      kind_type            k;
      logic [HANDLE_W-1:0] h;
      logic [COUNT_W-1:0]  n;
      for (int i = 0; i < words; i++) begin
         no_idle = (i % 100) >= 80;
         pick_word(k, h, n);
         send_word(k, h, n, 1'b0, '0);
      end
   endtask

   initial begin : stimulus
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (script[r])
         send_word(script[r].kind, script[r].handle, script[r].count,
                   script[r].typed, script[r].want);
      wait_drained();

      run_random(600);
      wait_drained();

      run_random(200);
      wait_drained();
      repeat (20) @(posedge clock);

      if (mismatches == 0 && expected_words.size() == 0)
         $display("[size_class_block_allocator_top] OK");
      else
         $display("[size_class_block_allocator_top] ERROR");
      $finish;
   end

   // Result side: a random hold-off before each word, plus one long hold that
   // backs the block up while the sender keeps offering.
   initial begin : receiver
      int hold;
      bit long_done;
      long_done = 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         hold = no_idle ? 0 : $urandom_range(0, 9);
         if (!long_done && rsp_seen >= 150) begin
            hold = 300;
            long_done = 1'b1;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0));
      end
   end

   always @(posedge clock) begin : check_words
      alloc_result_type got;
      alloc_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         rsp_seen <= rsp_seen + 1;
         got = {rsp_result_handle, rsp_byte_addr, rsp_status};
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result word handle %0d addr %h status %0d",
                        $time, got.hdl, got.addr, got.status);
         end else begin
            want = expected_words.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: word mismatch handle %0d/%0d addr %h/%h status %0d/%0d %s",
                           $time, want.hdl, got.hdl, want.addr, got.addr, want.status,
                           got.status, "(expected/actual)");
            end
         end
      end
   end

   initial begin : watchdog
      #2_000_000;
      $display("[size_class_block_allocator_top] ERROR");
      $finish;
   end

endmodule

`default_nettype wire
